// ===== hw/rtl/vpp_pkg.sv =====
// ----------------------------------------------------------------------------
// vpp_pkg
// Shared widths, register indexes and reset values of the vertex projector.
// ----------------------------------------------------------------------------
package vpp_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int SCALE_BITS   = 31;
    localparam int SIZE_BITS    = 13;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = SCALE_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_X_SCALE       = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_SCALE       = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd3;

    localparam logic [SCALE_BITS-1:0] X_SCALE_RST       = 31'd49152;
    localparam logic [SCALE_BITS-1:0] Y_SCALE_RST       = 31'd65536;
    localparam logic [SIZE_BITS-1:0]  SCREEN_WIDTH_RST  = 13'd800;
    localparam logic [SIZE_BITS-1:0]  SCREEN_HEIGHT_RST = 13'd600;

endpackage

// ===== hw/rtl/vertex_perspective_project_top.sv =====
// ----------------------------------------------------------------------------
// vertex_perspective_project_top
// Perspective projection and viewport mapping of camera-space vertices.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  input    | in_valid / in_stall     | vertex_x, vertex_y, vertex_z, last_in
//  output   | out_valid / out_stall   | screen_x, screen_y, w_zero, last_out
//  config   | cfg_write_en            | cfg_index, cfg_data
//
//  One vertex per cycle sustained while in_stall is low.
//  The two restoring dividers produce one quotient bit per stage.
//  Reset loads the default registers and empties the pipeline.
//  A stalled result moves into a skid register; the pipeline keeps running
//  until the skid register is full, then in_stall holds the input.
// ----------------------------------------------------------------------------
module vertex_perspective_project_top #(
    parameter int COORD_BITS = vpp_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = vpp_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [vpp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [vpp_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [COORD_BITS-1:0]      vertex_x,
    input  logic signed [COORD_BITS-1:0]      vertex_y,
    input  logic signed [COORD_BITS-1:0]      vertex_z,
    input  logic                              last_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [COORD_BITS-1:0]      screen_x,
    output logic signed [COORD_BITS-1:0]      screen_y,
    output logic                              w_zero,
    output logic                              last_out
);
    import vpp_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int SB = SCALE_BITS;
    localparam int RW = C + 1;
    localparam int PW = C + SB;
    localparam int CW = (SB > RW) ? SB : RW;
    localparam int TW = ((FRAC_BITS + 2 > C + 1) ? FRAC_BITS + 2 : C + 1) + 1;
    localparam int ZW = SIZE_BITS + 1;
    localparam int SW = TW + ZW;

    localparam logic signed [TW-1:0] ONE = {{(TW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [C-1:0] LIM_POS = {1'b0, {(C-1){1'b1}}};
    localparam logic [C-1:0] LIM_NEG = {1'b1, {(C-1){1'b0}}};
    localparam logic signed [SW-1:0] SMAX_W = {{(SW-C+1){1'b0}}, {(C-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN_W = {{(SW-C+1){1'b1}}, {(C-1){1'b0}}};

    // the most negative word counts as a magnitude of 2^C
    function automatic logic [RW-1:0] mag_of(input logic [C-1:0] v);
        begin
            if (v == LIM_NEG)
                return {1'b1, {C{1'b0}}};
            return v[C-1] ? {1'b0, ~v + 1'b1} : {1'b0, v};
        end
    endfunction

    function automatic logic [2*C:0] div_step(
        input logic [RW-1:0] rem,
        input logic [C-1:0]  word,
        input logic [RW-1:0] dvs
    );
        logic [RW:0]   trial;
        logic [RW:0]   diff;
        logic [RW-1:0] r_out;
        logic          q;
        begin
            trial = {rem, word[C-1]};
            diff  = trial - {1'b0, dvs};
            q     = (trial >= {1'b0, dvs});
            r_out = q ? diff[RW-1:0] : trial[RW-1:0];
            return {r_out, word[C-2:0], q};
        end
    endfunction

    logic [SB-1:0]        x_scale_reg;
    logic [SB-1:0]        y_scale_reg;
    logic [SIZE_BITS-1:0] screen_width_reg;
    logic [SIZE_BITS-1:0] screen_height_reg;

    logic en;

    // stage A: magnitudes and signs
    logic          a_valid_reg;
    logic [RW-1:0] a_mag_x_reg, a_mag_y_reg, a_mag_z_reg;
    logic          a_neg_x_reg, a_neg_y_reg, a_wz_reg, a_last_reg;
    logic [RW-1:0] a_mag_x_next, a_mag_y_next, a_mag_z_next;
    logic          w_neg;

    // stage B: products
    logic          b_valid_reg;
    logic [PW-1:0] b_prod_x_reg, b_prod_y_reg;
    logic [RW-1:0] b_dvs_reg;
    logic          b_neg_x_reg, b_neg_y_reg, b_wz_reg, b_last_reg;

    // divider stages, index 0 holds the initial remainder
    logic          d_valid_reg [C+1];
    logic [RW-1:0] d_rem_x_reg [C+1];
    logic [RW-1:0] d_rem_y_reg [C+1];
    logic [C-1:0]  d_word_x_reg [C+1];
    logic [C-1:0]  d_word_y_reg [C+1];
    logic [RW-1:0] d_dvs_reg [C+1];
    logic          d_ovf_x_reg [C+1];
    logic          d_ovf_y_reg [C+1];
    logic          d_neg_x_reg [C+1];
    logic          d_neg_y_reg [C+1];
    logic          d_wz_reg [C+1];
    logic          d_last_reg [C+1];
    logic [2*C:0]  d_step_x_next [C];
    logic [2*C:0]  d_step_y_next [C];
    logic [SB-1:0] hi_x, hi_y;

    // stage N: normalized terms
    logic                 n_valid_reg;
    logic signed [TW-1:0] n_term_x_reg, n_term_y_reg;
    logic                 n_wz_reg, n_last_reg;
    logic [C-1:0]         q_x, q_y, qs_x, qs_y, lim_x, lim_y;
    logic signed [C-1:0]  nx, ny;

    // stage M: screen products
    logic                 m_valid_reg;
    logic signed [SW-1:0] m_prod_x_reg, m_prod_y_reg;
    logic                 m_wz_reg, m_last_reg;

    // stage O: output and skid
    logic                 o_valid_reg;
    logic signed [C-1:0]  o_x_reg, o_y_reg;
    logic                 o_wz_reg, o_last_reg;
    logic signed [SW-1:0] adj_x, adj_y, half_x, half_y;
    logic signed [C-1:0]  sat_x, sat_y;

    logic                 skid_valid_reg;
    logic signed [C-1:0]  skid_x_reg, skid_y_reg;
    logic                 skid_wz_reg, skid_last_reg;

    assign en       = ~skid_valid_reg;
    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_scale_reg       <= X_SCALE_RST;
            y_scale_reg       <= Y_SCALE_RST;
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_X_SCALE:       x_scale_reg       <= cfg_data;
                REG_Y_SCALE:       y_scale_reg       <= cfg_data;
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[SIZE_BITS-1:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[SIZE_BITS-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        a_mag_x_next = mag_of(vertex_x);
        a_mag_y_next = mag_of(vertex_y);
        a_mag_z_next = mag_of(vertex_z);
        w_neg        = ~vertex_z[C-1];
    end

    always_comb
    begin
        hi_x = b_prod_x_reg[PW-1:C];
        hi_y = b_prod_y_reg[PW-1:C];
        for (int k = 0; k < C; k++)
        begin
            d_step_x_next[k] = div_step(d_rem_x_reg[k], d_word_x_reg[k], d_dvs_reg[k]);
            d_step_y_next[k] = div_step(d_rem_y_reg[k], d_word_y_reg[k], d_dvs_reg[k]);
        end
    end

    always_comb
    begin
        q_x   = d_word_x_reg[C];
        q_y   = d_word_y_reg[C];
        lim_x = d_neg_x_reg[C] ? LIM_NEG : LIM_POS;
        lim_y = d_neg_y_reg[C] ? LIM_NEG : LIM_POS;
        qs_x  = (d_ovf_x_reg[C] || (q_x > lim_x)) ? lim_x : q_x;
        qs_y  = (d_ovf_y_reg[C] || (q_y > lim_y)) ? lim_y : q_y;
        nx    = d_wz_reg[C] ? '0 : $signed(d_neg_x_reg[C] ? (~qs_x + 1'b1) : qs_x);
        ny    = d_wz_reg[C] ? '0 : $signed(d_neg_y_reg[C] ? (~qs_y + 1'b1) : qs_y);
    end

    always_comb
    begin
        adj_x  = m_prod_x_reg + $signed({{(SW-1){1'b0}}, m_prod_x_reg[SW-1]});
        adj_y  = m_prod_y_reg + $signed({{(SW-1){1'b0}}, m_prod_y_reg[SW-1]});
        half_x = adj_x >>> 1;
        half_y = adj_y >>> 1;
        sat_x  = (half_x > SMAX_W) ? SMAX_W[C-1:0] :
                 (half_x < SMIN_W) ? SMIN_W[C-1:0] : half_x[C-1:0];
        sat_y  = (half_y > SMAX_W) ? SMAX_W[C-1:0] :
                 (half_y < SMIN_W) ? SMIN_W[C-1:0] : half_y[C-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            for (int k = 0; k <= C; k++)
            begin
                d_valid_reg[k] <= 1'b0;
            end
            n_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg    <= in_valid;
            b_valid_reg    <= a_valid_reg;
            d_valid_reg[0] <= b_valid_reg;
            for (int k = 0; k < C; k++)
            begin
                d_valid_reg[k+1] <= d_valid_reg[k];
            end
            n_valid_reg <= d_valid_reg[C];
            m_valid_reg <= n_valid_reg;
            o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_x_reg <= a_mag_x_next;
            a_mag_y_reg <= a_mag_y_next;
            a_mag_z_reg <= a_mag_z_next;
            a_neg_x_reg <= vertex_x[C-1] ^ w_neg;
            a_neg_y_reg <= vertex_y[C-1] ^ w_neg;
            a_wz_reg    <= (vertex_z == '0);
            a_last_reg  <= last_in;

            b_prod_x_reg <= a_mag_x_reg[C] ? {x_scale_reg, {C{1'b0}}}
                          : {{C{1'b0}}, x_scale_reg} * {{SB{1'b0}}, a_mag_x_reg[C-1:0]};
            b_prod_y_reg <= a_mag_y_reg[C] ? {y_scale_reg, {C{1'b0}}}
                          : {{C{1'b0}}, y_scale_reg} * {{SB{1'b0}}, a_mag_y_reg[C-1:0]};
            b_dvs_reg    <= a_mag_z_reg;
            b_neg_x_reg  <= a_neg_x_reg;
            b_neg_y_reg  <= a_neg_y_reg;
            b_wz_reg     <= a_wz_reg;
            b_last_reg   <= a_last_reg;

            d_rem_x_reg[0]  <= RW'(hi_x);
            d_rem_y_reg[0]  <= RW'(hi_y);
            d_word_x_reg[0] <= b_prod_x_reg[C-1:0];
            d_word_y_reg[0] <= b_prod_y_reg[C-1:0];
            d_dvs_reg[0]    <= b_dvs_reg;
            d_ovf_x_reg[0]  <= (CW'(hi_x) >= CW'(b_dvs_reg));
            d_ovf_y_reg[0]  <= (CW'(hi_y) >= CW'(b_dvs_reg));
            d_neg_x_reg[0]  <= b_neg_x_reg;
            d_neg_y_reg[0]  <= b_neg_y_reg;
            d_wz_reg[0]     <= b_wz_reg;
            d_last_reg[0]   <= b_last_reg;

            for (int k = 0; k < C; k++)
            begin
                d_rem_x_reg[k+1]  <= d_step_x_next[k][2*C:C];
                d_rem_y_reg[k+1]  <= d_step_y_next[k][2*C:C];
                d_word_x_reg[k+1] <= d_step_x_next[k][C-1:0];
                d_word_y_reg[k+1] <= d_step_y_next[k][C-1:0];
                d_dvs_reg[k+1]    <= d_dvs_reg[k];
                d_ovf_x_reg[k+1]  <= d_ovf_x_reg[k];
                d_ovf_y_reg[k+1]  <= d_ovf_y_reg[k];
                d_neg_x_reg[k+1]  <= d_neg_x_reg[k];
                d_neg_y_reg[k+1]  <= d_neg_y_reg[k];
                d_wz_reg[k+1]     <= d_wz_reg[k];
                d_last_reg[k+1]   <= d_last_reg[k];
            end

            n_term_x_reg <= ONE + TW'(nx);
            n_term_y_reg <= ONE - TW'(ny);
            n_wz_reg     <= d_wz_reg[C];
            n_last_reg   <= d_last_reg[C];

            m_prod_x_reg <= SW'($signed({1'b0, screen_width_reg})) * SW'(n_term_x_reg);
            m_prod_y_reg <= SW'($signed({1'b0, screen_height_reg})) * SW'(n_term_y_reg);
            m_wz_reg     <= n_wz_reg;
            m_last_reg   <= n_last_reg;

            o_x_reg    <= sat_x;
            o_y_reg    <= sat_y;
            o_wz_reg   <= m_wz_reg;
            o_last_reg <= m_last_reg;
        end
    end

    // hold a stalled result in the skid register while the pipeline advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (en && o_valid_reg && out_stall)
        begin
            skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg && !out_stall)
        begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && o_valid_reg && out_stall)
        begin
            skid_x_reg    <= o_x_reg;
            skid_y_reg    <= o_y_reg;
            skid_wz_reg   <= o_wz_reg;
            skid_last_reg <= o_last_reg;
        end
    end

    assign out_valid = skid_valid_reg | o_valid_reg;
    assign screen_x  = skid_valid_reg ? skid_x_reg    : o_x_reg;
    assign screen_y  = skid_valid_reg ? skid_y_reg    : o_y_reg;
    assign w_zero    = skid_valid_reg ? skid_wz_reg   : o_wz_reg;
    assign last_out  = skid_valid_reg ? skid_last_reg : o_last_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the perspective projection and viewport mapping block.
// Vertices go in through the valid/stall input channel and are predicted at
// the cycle they are accepted. Each screen position that comes out is checked
// field by field against the oldest prediction. The run covers directed
// extremes, register extremes, random traffic under several idle and stall
// mixes, and a long output hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module tb;
    import vpp_pkg::*;

    localparam int CW              = COORD_BITS_DEF;
    localparam int FW              = FRAC_BITS_DEF;
    localparam int LATENCY         = CW + 6;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;

    localparam longint WORD_MAX = (longint'(1) << (CW - 1)) - 1;
    localparam longint WORD_MIN = -(longint'(1) << (CW - 1));

    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW - 1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW - 1){1'b0}}};
    localparam logic signed [CW-1:0] ONE   = 1 << FW;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 last;
    } vertex_t;

    typedef struct packed {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic                 wz;
        logic                 last;
    } screen_t;

    logic                        clk;
    logic                        rst_n        = 1'b0;
    logic                        cfg_write_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]     cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]    cfg_data     = '0;
    logic                        in_valid     = 1'b0;
    logic                        in_stall;
    logic signed [CW-1:0]        vertex_x     = '0;
    logic signed [CW-1:0]        vertex_y     = '0;
    logic signed [CW-1:0]        vertex_z     = '0;
    logic                        last_in      = 1'b0;
    logic                        out_valid;
    logic                        out_stall    = 1'b0;
    logic signed [CW-1:0]        screen_x;
    logic signed [CW-1:0]        screen_y;
    logic                        w_zero;
    logic                        last_out;

    logic [SCALE_BITS-1:0] x_scale_q = X_SCALE_RST;
    logic [SCALE_BITS-1:0] y_scale_q = Y_SCALE_RST;
    logic [SIZE_BITS-1:0]  width_q   = SCREEN_WIDTH_RST;
    logic [SIZE_BITS-1:0]  height_q  = SCREEN_HEIGHT_RST;

    screen_t     projected_q[$];
    int          error_count   = 0;
    int          quiet_cycles  = 0;
    int          hold_off_left = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;

    vertex_perspective_project_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .vertex_z     (vertex_z),
        .last_in      (last_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .screen_x     (screen_x),
        .screen_y     (screen_y),
        .w_zero       (w_zero),
        .last_out     (last_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // the most negative word counts as a magnitude of 2^CW
    function automatic longint coord_mag(input logic signed [CW-1:0] c);
        if (c == C_MIN)
            return longint'(1) << CW;
        return ($signed(c) < 0) ? -longint'($signed(c)) : longint'($signed(c));
    endfunction

    function automatic longint normalized(input logic [SCALE_BITS-1:0] scale,
                                          input logic signed [CW-1:0] coord,
                                          input longint w_mag, input bit w_neg);
        longint c_mag;
        longint quo;
        longint lim;
        bit     neg;
        c_mag = coord_mag(coord);
        neg   = (($signed(coord) < 0) != w_neg);
        quo   = (longint'(scale) * c_mag) / w_mag;
        lim   = neg ? -WORD_MIN : WORD_MAX;
        if (quo > lim)
            quo = lim;
        return neg ? -quo : quo;
    endfunction

    function automatic logic signed [CW-1:0] to_pixels(input logic [SIZE_BITS-1:0] size,
                                                       input longint term);
        longint t;
        t = (longint'(size) * term) / 2;
        if (t > WORD_MAX)
            t = WORD_MAX;
        if (t < WORD_MIN)
            t = WORD_MIN;
        return t[CW-1:0];
    endfunction

    function automatic screen_t project_vertex(input vertex_t v);
        screen_t s;
        longint  nx;
        longint  ny;
        longint  w_mag;
        bit      w_neg;
        nx   = 0;
        ny   = 0;
        s.wz = (v.z == '0);
        if (!s.wz)
        begin
            w_mag = coord_mag(v.z);
            w_neg = ($signed(v.z) > 0);
            nx    = normalized(x_scale_q, v.x, w_mag, w_neg);
            ny    = normalized(y_scale_q, v.y, w_mag, w_neg);
        end
        s.sx   = to_pixels(width_q, (longint'(1) << FW) + nx);
        s.sy   = to_pixels(height_q, (longint'(1) << FW) - ny);
        s.last = v.last;
        return s;
    endfunction

    function automatic vertex_t vtx(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                                    input logic signed [CW-1:0] z, input logic last);
        vertex_t v;
        v.x    = x;
        v.y    = y;
        v.z    = z;
        v.last = last;
        return v;
    endfunction

    function automatic vertex_t random_vertex();
        vertex_t     v;
        int unsigned z_mag;
        v.last = 1'($urandom_range(1, 0));
        if ($urandom_range(99, 0) < 75)
        begin
            z_mag = $urandom_range(1 << 26, 1);
            v.z   = -CW'(z_mag);
            v.x   = CW'($urandom_range(2 * z_mag, 0)) - CW'(z_mag);
            v.y   = CW'($urandom_range(2 * z_mag, 0)) - CW'(z_mag);
        end
        else
        begin
            v.x = CW'($urandom);
            v.y = CW'($urandom);
            case ($urandom_range(3, 0))
                0:       v.z = '0;
                1:       v.z = CW'($urandom_range(1 << 24, 1));
                default: v.z = CW'($urandom);
            endcase
        end
        return v;
    endfunction

    function automatic logic [SCALE_BITS-1:0] random_scale();
        case ($urandom_range(3, 0))
            0:       return SCALE_BITS'($urandom_range(1 << 18, 0));
            1:       return SCALE_BITS'($urandom);
            default: return SCALE_BITS'($urandom_range(2 << 16, 1 << 15));
        endcase
    endfunction

    function automatic logic [SIZE_BITS-1:0] random_size();
        if ($urandom_range(9, 0) == 0)
            return {SIZE_BITS{1'b1}};
        return SIZE_BITS'($urandom_range(4096, 1));
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $realtime, what);
        error_count++;
    endtask

    task automatic check_result();
        screen_t exp;
        if (projected_q.size() == 0)
        begin
            report_mismatch("screen position with no vertex outstanding");
            return;
        end
        exp = projected_q.pop_front();
        if (screen_x !== exp.sx)
            report_mismatch($sformatf("screen_x %0d, predicted %0d", screen_x, exp.sx));
        if (screen_y !== exp.sy)
            report_mismatch($sformatf("screen_y %0d, predicted %0d", screen_y, exp.sy));
        if (w_zero !== exp.wz)
            report_mismatch($sformatf("w_zero %b, predicted %b", w_zero, exp.wz));
        if (last_out !== exp.last)
            report_mismatch($sformatf("last_out %b, predicted %b", last_out, exp.last));
    endtask

    task automatic send_vertex(input vertex_t v);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        vertex_x <= v.x;
        vertex_y <= v.y;
        vertex_z <= v.z;
        last_in  <= v.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        projected_q.push_back(project_vertex(v));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (projected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        case (idx)
            REG_X_SCALE:       x_scale_q = data;
            REG_Y_SCALE:       y_scale_q = data;
            REG_SCREEN_WIDTH:  width_q   = data[SIZE_BITS-1:0];
            REG_SCREEN_HEIGHT: height_q  = data[SIZE_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_registers(input logic [SCALE_BITS-1:0] xs, input logic [SCALE_BITS-1:0] ys,
                                 input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h);
        logic [CFG_DATA_BITS-1:0] data;
        wait_drained();
        put_reg(REG_X_SCALE, xs);
        put_reg(REG_Y_SCALE, ys);
        data                  = CFG_DATA_BITS'($urandom);
        data[SIZE_BITS-1:0]   = w;
        put_reg(REG_SCREEN_WIDTH, data);
        data                  = CFG_DATA_BITS'($urandom);
        data[SIZE_BITS-1:0]   = h;
        put_reg(REG_SCREEN_HEIGHT, data);
        cfg_write_en <= 1'b0;
    endtask

    task automatic send_probe_set();
        send_vertex(vtx(ONE, -ONE, -ONE, 1'b0));
        send_vertex(vtx(C_MAX, C_MIN, -ONE, 1'b1));
        send_vertex(vtx(C_MIN, C_MAX, '0, 1'b1));
    endtask

    task automatic test_directed_cases();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_vertex(vtx('0, '0, -ONE, 1'b0));
        send_vertex(vtx(ONE, ONE, -ONE, 1'b1));
        send_vertex(vtx(ONE, -ONE, '0, 1'b1));
        send_vertex(vtx(C_MIN, C_MAX, '0, 1'b0));
        send_vertex(vtx(ONE, -ONE, 2 * ONE, 1'b0));
        send_vertex(vtx(C_MAX, C_MAX, C_MAX, 1'b1));
        send_vertex(vtx(C_MIN, C_MIN, C_MIN, 1'b0));
        send_vertex(vtx(C_MAX, C_MIN, -1, 1'b1));
        send_vertex(vtx(C_MIN, C_MAX, 1, 1'b0));
        send_vertex(vtx(C_MIN, -1, C_MIN, 1'b1));
        send_vertex(vtx('0, '0, -1, 1'b0));
        send_vertex(vtx(C_MAX, 1, C_MIN, 1'b1));
    endtask

    task automatic test_register_extremes();
        set_registers({SCALE_BITS{1'b1}}, {SCALE_BITS{1'b1}}, {SIZE_BITS{1'b1}},
                      {SIZE_BITS{1'b1}});
        send_probe_set();
        set_registers('0, '0, '0, '0);
        send_probe_set();
        set_registers(SCALE_BITS'(1), SCALE_BITS'(1), SIZE_BITS'(1), SIZE_BITS'(4096));
        send_probe_set();
    endtask

    task automatic test_random_traffic();
        int unsigned idle_plan [4];
        int unsigned stall_plan [4];
        idle_plan  = '{0, 80, 0, 23};
        stall_plan = '{0, 0, 80, 23};
        for (int p = 0; p < 4; p++)
        begin
            set_registers(random_scale(), random_scale(), random_size(), random_size());
            send_idle_pct = idle_plan[p];
            stall_pct     = stall_plan[p];
            repeat (90) send_vertex(random_vertex());
        end
    endtask

    task automatic test_output_backpressure();
        set_registers(X_SCALE_RST, Y_SCALE_RST, SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_off_left <= HOLD_OFF_CYCLES;
        repeat (80) send_vertex(random_vertex());
    endtask

    // receive side: check each transaction, then pick the next stall
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                check_result();
            if (hold_off_left != 0)
            begin
                out_stall     <= 1'b1;
                hold_off_left <= hold_off_left - 1;
            end
            else
            begin
                out_stall <= ($urandom_range(99, 0) < stall_pct);
            end
        end
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_register_extremes();
        test_random_traffic();
        test_output_backpressure();
        wait_drained();
        repeat (LATENCY + 8) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
